>>> rtl/core/volume_box_downsample_macros.svh
// ----------------------------------------------------------------------------
// Volume box downsample assertion macros
// Concurrent checks on clk with synchronous reset rst; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef VOLUME_BOX_DOWNSAMPLE_MACROS_SVH
`define VOLUME_BOX_DOWNSAMPLE_MACROS_SVH
`ifndef SYNTHESIS
`define VBD_ASSERT_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
`define VBD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define VBD_ASSERT_IMPLIES(label, cond, prop, msg)
`define VBD_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

>>> rtl/core/vbd_pkg.sv
// ----------------------------------------------------------------------------
// Volume box downsample package
// Shared widths, defaults, register indexes and control structs.
// ----------------------------------------------------------------------------
package vbd_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_FACTOR  = 8;
  localparam int DEF_VOXEL_BITS  = 8;

  localparam int COORD_BITS      = 12;
  localparam int SUM_BITS        = 17;
  localparam int FACTOR_REG_BITS = 4;
  localparam int SIZE_REG_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 13;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_Z      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_DEPTH  = 3'd5;

  localparam logic [FACTOR_REG_BITS-1:0] FACTOR_RESET = 4'd2;
  localparam logic [SIZE_REG_BITS-1:0]   SIZE_RESET   = 13'd256;

  typedef struct packed {
    logic [FACTOR_REG_BITS-1:0] factor_x;
    logic [FACTOR_REG_BITS-1:0] factor_y;
    logic [FACTOR_REG_BITS-1:0] factor_z;
    logic [SIZE_REG_BITS-1:0]   source_width;
    logic [SIZE_REG_BITS-1:0]   source_height;
    logic [SIZE_REG_BITS-1:0]   source_depth;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/core/vbd_voxel_if.sv
// ----------------------------------------------------------------------------
// Voxel input channel
// Valid/ready channel carrying one source voxel per item.
// ----------------------------------------------------------------------------
interface vbd_voxel_if #(
  parameter int VOXEL_BITS = vbd_pkg::DEF_VOXEL_BITS
);
  logic                  valid;
  logic                  ready;
  logic [VOXEL_BITS-1:0] voxel;

  modport source (output valid, output voxel, input ready);
  modport sink (input valid, input voxel, output ready);
endinterface

>>> rtl/core/vbd_result_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one destination voxel per item.
// ----------------------------------------------------------------------------
interface vbd_result_if #(
  parameter int VOXEL_BITS = vbd_pkg::DEF_VOXEL_BITS
);
  logic                            valid;
  logic                            ready;
  logic [VOXEL_BITS-1:0]           mean_value;
  logic [vbd_pkg::COORD_BITS-1:0]  dest_x;
  logic [vbd_pkg::COORD_BITS-1:0]  dest_y;
  logic [vbd_pkg::COORD_BITS-1:0]  dest_z;
  logic                            volume_done;

  modport source (output valid, output mean_value, output dest_x, output dest_y,
                  output dest_z, output volume_done, input ready);
  modport sink (input valid, input mean_value, input dest_x, input dest_y,
                input dest_z, input volume_done, output ready);
endinterface

>>> rtl/core/vbd_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface vbd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vbd_pkg::CFG_INDEX_BITS-1:0] index;
  logic [vbd_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/vbd_cfg.sv
// ----------------------------------------------------------------------------
// Volume box downsample configuration registers
// Decodes register writes and holds the raw factor and size registers.
// ----------------------------------------------------------------------------
module vbd_cfg (
  input  logic               clk,
  input  logic               rst,
  vbd_cfg_if.sink            cfg,
  output vbd_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.factor_x      <= vbd_pkg::FACTOR_RESET;
      regs.factor_y      <= vbd_pkg::FACTOR_RESET;
      regs.factor_z      <= vbd_pkg::FACTOR_RESET;
      regs.source_width  <= vbd_pkg::SIZE_RESET;
      regs.source_height <= vbd_pkg::SIZE_RESET;
      regs.source_depth  <= vbd_pkg::SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        vbd_pkg::REG_FACTOR_X: begin
          regs.factor_x <= vbd_pkg::FACTOR_REG_BITS'(cfg.data);
        end
        vbd_pkg::REG_FACTOR_Y: begin
          regs.factor_y <= vbd_pkg::FACTOR_REG_BITS'(cfg.data);
        end
        vbd_pkg::REG_FACTOR_Z: begin
          regs.factor_z <= vbd_pkg::FACTOR_REG_BITS'(cfg.data);
        end
        vbd_pkg::REG_SOURCE_WIDTH: begin
          regs.source_width <= vbd_pkg::SIZE_REG_BITS'(cfg.data);
        end
        vbd_pkg::REG_SOURCE_HEIGHT: begin
          regs.source_height <= vbd_pkg::SIZE_REG_BITS'(cfg.data);
        end
        vbd_pkg::REG_SOURCE_DEPTH: begin
          regs.source_depth <= vbd_pkg::SIZE_REG_BITS'(cfg.data);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/vbd_col_mem.sv
// ----------------------------------------------------------------------------
// Column partial-sum memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vbd_col_mem #(
  parameter int DEPTH = vbd_pkg::DEF_MAX_WIDTH,
  parameter int AW    = 12,
  parameter int DW    = vbd_pkg::SUM_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/vbd_div.sv
// ----------------------------------------------------------------------------
// Block mean divider
// Forms fx*fy*fz as fx*fy and then times fz, checks for saturation, then
// produces the quotient by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module vbd_div #(
  parameter int FW         = 4,
  parameter int VOXEL_BITS = vbd_pkg::DEF_VOXEL_BITS,
  parameter int SUMW       = vbd_pkg::SUM_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SUMW-1:0]      dividend,
  input  logic [FW-1:0]        fx,
  input  logic [FW-1:0]        fy,
  input  logic [FW-1:0]        fz,
  output vbd_pkg::div_status_t status,
  output logic [VOXEL_BITS-1:0] quotient
);

  localparam int CW = 3 * FW;
  localparam int DW = ((SUMW > CW + VOXEL_BITS) ? SUMW : CW + VOXEL_BITS) + 1;
  localparam int KW = $clog2(VOXEL_BITS + 1);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_CHK, D_STEP} phase_t;

  phase_t                phase;
  logic                  busy;
  logic                  done;
  logic [DW-1:0]         rem;
  logic [DW-1:0]         dsh;
  logic [CW-1:0]         prod;
  logic [VOXEL_BITS-1:0] q;
  logic [KW-1:0]         steps;
  logic                  ovf;
  logic                  ge;

  assign ovf = rem >= (DW'(prod) << VOXEL_BITS);
  assign ge  = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (phase)
        D_IDLE: begin
          if (start) begin
            phase <= D_MUL;
            busy  <= 1'b1;
            done  <= 1'b0;
            rem   <= DW'(dividend);
            prod  <= CW'(fx) * CW'(fy);
          end
        end
        D_MUL: begin
          phase <= D_CHK;
          prod  <= prod * CW'(fz);
        end
        D_CHK: begin
          if (ovf) begin
            phase <= D_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
            q     <= '1;
          end else begin
            phase <= D_STEP;
            dsh   <= DW'(prod) << (VOXEL_BITS - 1);
            steps <= KW'(VOXEL_BITS);
            q     <= '0;
          end
        end
        D_STEP: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          q     <= (q << 1) | VOXEL_BITS'(ge);
          dsh   <= dsh >> 1;
          steps <= steps - KW'(1);
          if (steps == KW'(1)) begin
            phase <= D_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          phase <= D_IDLE;
        end
      endcase
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = q;

endmodule

>>> rtl/core/volume_box_downsample.sv
// ----------------------------------------------------------------------------
// Volume box downsample
// Averages each fx by fy by fz block of a raster-order voxel stream into one
// destination voxel. A voxel that does not close an x block, or that closes
// one in the first row and plane of its block, does not hold the stream; one
// that closes an x block elsewhere holds it for the read-modify-write of the
// column partial-sum memory (registered read data). A voxel that completes
// a block also holds it for the divider, which forms the mean one quotient
// bit per cycle, and until the result register is free, before the next
// voxel is taken. The column memory needs no clearing pass: the first x
// block of each block row and plane overwrites its entry.
// ----------------------------------------------------------------------------
`include "volume_box_downsample_macros.svh"

module volume_box_downsample #(
  parameter int MAX_WIDTH  = vbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = vbd_pkg::DEF_MAX_FACTOR,
  parameter int VOXEL_BITS = vbd_pkg::DEF_VOXEL_BITS
) (
  input  logic       clk,
  input  logic       rst,
  vbd_cfg_if.sink    cfg,
  vbd_voxel_if.sink  src,
  vbd_result_if.source dst
);

  localparam int FW   = $clog2(MAX_FACTOR + 1);
  localparam int SW   = $clog2(MAX_WIDTH + 1);
  localparam int PW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int OW   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int EW   = ((SW > FW) ? SW : FW) + 2;
  localparam int SUMW = vbd_pkg::SUM_BITS;
  localparam int CB   = vbd_pkg::COORD_BITS;

  typedef enum logic [1:0] {S_RUN, S_RMW, S_DIV} state_t;

  function automatic logic [FW-1:0] eff_factor(
    input logic [vbd_pkg::FACTOR_REG_BITS-1:0] f
  );
    if (f == '0) return FW'(1);
    if (int'(f) > MAX_FACTOR) return FW'(MAX_FACTOR);
    return FW'(f);
  endfunction

  function automatic logic [SW-1:0] eff_size(
    input logic [vbd_pkg::SIZE_REG_BITS-1:0] s
  );
    if (s == '0) return SW'(1);
    if (int'(s) > MAX_WIDTH) return SW'(MAX_WIDTH);
    return SW'(s);
  endfunction

  vbd_pkg::cfg_regs_t   regs;
  vbd_pkg::div_status_t div_st;

  logic [FW-1:0] fx, fy, fz;
  logic [SW-1:0] w, h, d;

  state_t state;

  logic [PW-1:0] x, xs, bx;
  logic [PW-1:0] y, ys, by;
  logic [PW-1:0] z, zs, bz;
  logic [OW-1:0] ox, oy, oz;

  logic [SUMW-1:0] run_sum;
  logic [SUMW-1:0] rs_new;
  logic [SUMW-1:0] rmw_sum;
  logic [SUMW-1:0] mem_rdata;
  logic [SUMW-1:0] mem_wdata;
  logic [SUMW-1:0] div_dividend;
  logic [PW-1:0]   mem_waddr;

  logic [PW-1:0]   p_bx, p_by, p_bz;
  logic            p_last, p_done;
  logic [SUMW-1:0] p_sum;

  logic                  out_valid;
  logic [VOXEL_BITS-1:0] out_mean;
  logic [CB-1:0]         out_x, out_y, out_z;
  logic                  out_done;
  logic [VOXEL_BITS-1:0] div_q;

  logic accept, x_wrap, y_wrap, z_wrap;
  logic ox_end, oy_end, oz_end;
  logic valid_x, valid_y, valid_z, last_x, last_y, last_z;
  logic blk_valid, col_step, col_first, col_last;
  logic mem_rd_en, mem_we, div_start, out_load;

  vbd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign fx = eff_factor(regs.factor_x);
  assign fy = eff_factor(regs.factor_y);
  assign fz = eff_factor(regs.factor_z);
  assign w  = eff_size(regs.source_width);
  assign h  = eff_size(regs.source_height);
  assign d  = eff_size(regs.source_depth);

  assign x_wrap = (EW'(x) + EW'(1)) >= EW'(w);
  assign y_wrap = (EW'(y) + EW'(1)) >= EW'(h);
  assign z_wrap = (EW'(z) + EW'(1)) >= EW'(d);

  assign ox_end = (EW'(ox) + EW'(1)) == EW'(fx);
  assign oy_end = (EW'(oy) + EW'(1)) == EW'(fy);
  assign oz_end = (EW'(oz) + EW'(1)) == EW'(fz);

  assign valid_x = (EW'(xs) + EW'(fx)) <= EW'(w);
  assign valid_y = (EW'(ys) + EW'(fy)) <= EW'(h);
  assign valid_z = (EW'(zs) + EW'(fz)) <= EW'(d);
  assign last_x  = (EW'(xs) + EW'(fx) + EW'(fx)) > EW'(w);
  assign last_y  = (EW'(ys) + EW'(fy) + EW'(fy)) > EW'(h);
  assign last_z  = (EW'(zs) + EW'(fz) + EW'(fz)) > EW'(d);

  assign src.ready = (state == S_RUN);
  assign accept    = src.valid && src.ready;
  assign blk_valid = valid_x && valid_y && valid_z;

  assign rs_new    = (ox == '0) ? SUMW'(src.voxel) : run_sum + SUMW'(src.voxel);
  assign col_step  = accept && blk_valid && ox_end;
  assign col_first = (oy == '0) && (oz == '0);
  assign col_last  = oy_end && oz_end;

  assign rmw_sum      = mem_rdata + p_sum;
  assign mem_rd_en    = col_step && !col_first;
  assign mem_we       = (col_step && col_first) || (state == S_RMW);
  assign mem_waddr    = (state == S_RMW) ? p_bx : bx;
  assign mem_wdata    = (state == S_RMW) ? rmw_sum : rs_new;
  assign div_dividend = (state == S_RMW) ? rmw_sum : rs_new;
  assign div_start    = (col_step && col_first && col_last) ||
                        ((state == S_RMW) && p_last);
  assign out_load     = (state == S_DIV) && div_st.done && (!out_valid || dst.ready);

  vbd_col_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (PW),
    .DW    (SUMW)
  ) u_col_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_rd_en),
    .raddr (bx),
    .rdata (mem_rdata)
  );

  vbd_div #(
    .FW         (FW),
    .VOXEL_BITS (VOXEL_BITS),
    .SUMW       (SUMW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .fx       (fx),
    .fy       (fy),
    .fz       (fz),
    .status   (div_st),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
      run_sum   <= '0;
      x  <= '0; xs <= '0; bx <= '0; ox <= '0;
      y  <= '0; ys <= '0; by <= '0; oy <= '0;
      z  <= '0; zs <= '0; bz <= '0; oz <= '0;
    end else begin
      case (state)
        S_RUN: begin
          if (mem_rd_en) begin
            state <= S_RMW;
          end else if (div_start) begin
            state <= S_DIV;
          end
        end
        S_RMW: begin
          state <= p_last ? S_DIV : S_RUN;
        end
        S_DIV: begin
          if (out_load) begin
            state <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end

      if (accept && blk_valid) begin
        run_sum <= rs_new;
      end

      // advance the raster position and block offsets
      if (accept) begin
        if (x_wrap) begin
          x <= '0; xs <= '0; bx <= '0; ox <= '0;
          if (y_wrap) begin
            y <= '0; ys <= '0; by <= '0; oy <= '0;
            if (z_wrap) begin
              z <= '0; zs <= '0; bz <= '0; oz <= '0;
            end else begin
              z <= z + PW'(1);
              if (oz_end) begin
                oz <= '0;
                zs <= PW'(EW'(zs) + EW'(fz));
                bz <= bz + PW'(1);
              end else begin
                oz <= oz + OW'(1);
              end
            end
          end else begin
            y <= y + PW'(1);
            if (oy_end) begin
              oy <= '0;
              ys <= PW'(EW'(ys) + EW'(fy));
              by <= by + PW'(1);
            end else begin
              oy <= oy + OW'(1);
            end
          end
        end else begin
          x <= x + PW'(1);
          if (ox_end) begin
            ox <= '0;
            xs <= PW'(EW'(xs) + EW'(fx));
            bx <= bx + PW'(1);
          end else begin
            ox <= ox + OW'(1);
          end
        end
      end
    end

    if (col_step) begin
      p_bx   <= bx;
      p_by   <= by;
      p_bz   <= bz;
      p_last <= col_last;
      p_done <= last_x && last_y && last_z;
      p_sum  <= rs_new;
    end

    if (out_load) begin
      out_mean <= div_q;
      out_x    <= CB'(p_bx);
      out_y    <= CB'(p_by);
      out_z    <= CB'(p_bz);
      out_done <= p_done;
    end
  end

  assign dst.valid       = out_valid;
  assign dst.mean_value  = out_mean;
  assign dst.dest_x      = out_x;
  assign dst.dest_y      = out_y;
  assign dst.dest_z      = out_z;
  assign dst.volume_done = out_done;

  `VBD_ASSERT_NEXT(a_rd_then_rmw, mem_rd_en, state == S_RMW, "column read not followed by write-back")
  `VBD_ASSERT_IMPLIES(a_div_free_on_start, div_start, !div_st.busy, "divider started while busy")
  `VBD_ASSERT_IMPLIES(a_no_accept_in_div, div_st.busy, !src.ready, "item taken during division")
  `VBD_ASSERT_IMPLIES(a_out_from_div, $rose(out_valid), $past(state == S_DIV), "result not from divider")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume box downsample testbench
// Streams whole volumes under a series of block factors and source sizes,
// predicts every block mean with its destination coordinates, and checks each
// result item in order; both channels stall at random until the last phases.
// ----------------------------------------------------------------------------
module testbench;
  import vbd_pkg::*;

  localparam int VOXEL_W      = DEF_VOXEL_BITS;
  localparam int SETTLE       = 32;
  localparam int RANDOM_ITEMS = 650;
  localparam int PRINT_LIMIT  = 50;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL} fill_t;

  typedef struct packed {
    logic [VOXEL_W-1:0]    mean_value;
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
    logic [COORD_BITS-1:0] dest_z;
    logic                  volume_done;
  } dest_voxel_t;

  class downsample_scoreboard;
    logic [FACTOR_REG_BITS-1:0] factor_reg [3];
    logic [SIZE_REG_BITS-1:0]   size_reg [3];
    int unsigned                pos [3];
    logic [SUM_BITS-1:0]        run_sum;
    logic [SUM_BITS-1:0]        partial_sums [DEF_MAX_WIDTH];
    dest_voxel_t                block_means [$];
    int                         errors;

    function new();
      errors = 0;
      run_sum = '0;
      for (int a = 0; a < 3; a++) begin
        factor_reg[a] = FACTOR_RESET;
        size_reg[a] = SIZE_RESET;
        pos[a] = 0;
      end
      foreach (partial_sums[i]) partial_sums[i] = '0;
    endfunction

    function int unsigned eff_factor(logic [FACTOR_REG_BITS-1:0] f);
      if (f == 0) return 1;
      if (f > DEF_MAX_FACTOR) return DEF_MAX_FACTOR;
      return f;
    endfunction

    function int unsigned eff_size(logic [SIZE_REG_BITS-1:0] s);
      if (s == 0) return 1;
      if (s > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return s;
    endfunction

    function int unsigned volume_voxels();
      return eff_size(size_reg[0]) * eff_size(size_reg[1]) * eff_size(size_reg[2]);
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                               logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_FACTOR_X:      factor_reg[0] = data[FACTOR_REG_BITS-1:0];
        REG_FACTOR_Y:      factor_reg[1] = data[FACTOR_REG_BITS-1:0];
        REG_FACTOR_Z:      factor_reg[2] = data[FACTOR_REG_BITS-1:0];
        REG_SOURCE_WIDTH:  size_reg[0] = data[SIZE_REG_BITS-1:0];
        REG_SOURCE_HEIGHT: size_reg[1] = data[SIZE_REG_BITS-1:0];
        REG_SOURCE_DEPTH:  size_reg[2] = data[SIZE_REG_BITS-1:0];
        default: ;
      endcase
    endfunction

    // returns 1 when the voxel falls inside a whole block
    function bit note_voxel(logic [VOXEL_W-1:0] v);
      int unsigned f [3];
      int unsigned lim [3];
      int unsigned blk [3];
      int unsigned off [3];
      int unsigned mean;
      bit          in_block;
      dest_voxel_t res;
      in_block = 1'b1;
      for (int a = 0; a < 3; a++) begin
        f[a] = eff_factor(factor_reg[a]);
        lim[a] = eff_size(size_reg[a]);
        blk[a] = pos[a] / f[a];
        off[a] = pos[a] % f[a];
        if (blk[a] >= lim[a] / f[a]) in_block = 1'b0;
      end
      if (in_block) begin
        run_sum = (off[0] == 0) ? SUM_BITS'(v) : run_sum + SUM_BITS'(v);
        if (off[0] == f[0] - 1) begin
          if (off[1] == 0 && off[2] == 0) partial_sums[blk[0]] = run_sum;
          else partial_sums[blk[0]] = partial_sums[blk[0]] + run_sum;
          if (off[1] == f[1] - 1 && off[2] == f[2] - 1) begin
            mean = partial_sums[blk[0]] / (f[0] * f[1] * f[2]);
            res.mean_value = (mean > (1 << VOXEL_W) - 1) ? {VOXEL_W{1'b1}} : VOXEL_W'(mean);
            res.dest_x = COORD_BITS'(blk[0]);
            res.dest_y = COORD_BITS'(blk[1]);
            res.dest_z = COORD_BITS'(blk[2]);
            res.volume_done = (blk[0] == lim[0] / f[0] - 1) &&
                              (blk[1] == lim[1] / f[1] - 1) &&
                              (blk[2] == lim[2] / f[2] - 1);
            block_means.push_back(res);
          end
        end
      end
      pos[0]++;
      if (pos[0] >= lim[0]) begin
        pos[0] = 0;
        pos[1]++;
        if (pos[1] >= lim[1]) begin
          pos[1] = 0;
          pos[2]++;
          if (pos[2] >= lim[2]) pos[2] = 0;
        end
      end
      return in_block;
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(dest_voxel_t got);
      dest_voxel_t want;
      if (block_means.size() == 0) begin
        report($sformatf("unexpected item at x=%0d y=%0d z=%0d",
                         got.dest_x, got.dest_y, got.dest_z));
        return;
      end
      want = block_means.pop_front();
      if (got.mean_value !== want.mean_value)
        report($sformatf("mean_value %0d, want %0d at x=%0d y=%0d z=%0d", got.mean_value,
                         want.mean_value, want.dest_x, want.dest_y, want.dest_z));
      if (got.dest_x !== want.dest_x)
        report($sformatf("dest_x %0d, want %0d", got.dest_x, want.dest_x));
      if (got.dest_y !== want.dest_y)
        report($sformatf("dest_y %0d, want %0d", got.dest_y, want.dest_y));
      if (got.dest_z !== want.dest_z)
        report($sformatf("dest_z %0d, want %0d", got.dest_z, want.dest_z));
      if (got.volume_done !== want.volume_done)
        report($sformatf("volume_done %0b, want %0b at x=%0d y=%0d z=%0d", got.volume_done,
                         want.volume_done, want.dest_x, want.dest_y, want.dest_z));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 48;

  downsample_scoreboard sb;

  vbd_cfg_if    cfg_ch ();
  vbd_voxel_if  voxel_ch ();
  vbd_result_if dest_ch ();

  volume_box_downsample i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .src (voxel_ch),
    .dst (dest_ch)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    dest_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    dest_voxel_t got;
    if (!rst && dest_ch.valid && dest_ch.ready) begin
      got.mean_value = dest_ch.mean_value;
      got.dest_x = dest_ch.dest_x;
      got.dest_y = dest_ch.dest_y;
      got.dest_z = dest_ch.dest_z;
      got.volume_done = dest_ch.volume_done;
      sb.check_result(got);
    end
  end

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // drop valid, wait for every expected item, then let the block settle
  task automatic hold_until_drained(input int unsigned settle);
    voxel_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.block_means.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [FACTOR_REG_BITS-1:0] fx,
                                input logic [FACTOR_REG_BITS-1:0] fy,
                                input logic [FACTOR_REG_BITS-1:0] fz,
                                input logic [SIZE_REG_BITS-1:0] w,
                                input logic [SIZE_REG_BITS-1:0] h,
                                input logic [SIZE_REG_BITS-1:0] d);
    hold_until_drained(SETTLE);
    write_reg(REG_FACTOR_X, CFG_DATA_BITS'(fx));
    write_reg(REG_FACTOR_Y, CFG_DATA_BITS'(fy));
    write_reg(REG_FACTOR_Z, CFG_DATA_BITS'(fz));
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_SOURCE_DEPTH, d);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_voxel(input logic [VOXEL_W-1:0] v, output bit counted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      voxel_ch.valid <= 1'b0;
      @(negedge clk);
    end
    voxel_ch.valid <= 1'b1;
    voxel_ch.voxel <= v;
    @(posedge clk);
    while (!voxel_ch.ready) @(posedge clk);
    counted = sb.note_voxel(v);
    @(negedge clk);
  endtask

  task automatic stream_volume(input fill_t fill, input bit hold_midway,
                               inout int unsigned used);
    int unsigned        total;
    int unsigned        pause_at;
    logic [VOXEL_W-1:0] v;
    bit                 counted;
    total = sb.volume_voxels();
    pause_at = hold_midway ? $urandom_range(0, total - 1) : total;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == pause_at) hold_until_drained(0);
      case (fill)
        FILL_ZERO: v = '0;
        FILL_FULL: v = {VOXEL_W{1'b1}};
        default: begin
          if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? {VOXEL_W{1'b1}} : '0;
          else v = VOXEL_W'($urandom());
        end
      endcase
      push_voxel(v, counted);
      if (counted) used++;
    end
  endtask

  task automatic random_settings();
    logic [FACTOR_REG_BITS-1:0] f [3];
    logic [SIZE_REG_BITS-1:0]   s [3];
    int unsigned                ef;
    int unsigned                roll;
    int unsigned                voxels;
    do begin
      voxels = 1;
      for (int a = 0; a < 3; a++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) f[a] = '0;
        else if (roll < 80) f[a] = FACTOR_REG_BITS'($urandom_range(1, 3));
        else if (roll < 94) f[a] = FACTOR_REG_BITS'($urandom_range(4, DEF_MAX_FACTOR));
        else f[a] = FACTOR_REG_BITS'($urandom_range(DEF_MAX_FACTOR + 1, 15));
        ef = sb.eff_factor(f[a]);
        if ($urandom_range(0, 99) < 8) s[a] = SIZE_REG_BITS'($urandom_range(0, ef - 1));
        else s[a] = SIZE_REG_BITS'(ef * $urandom_range(1, 2) + $urandom_range(0, ef - 1));
        voxels *= sb.eff_size(s[a]);
      end
    end while (voxels > 160);
    apply_settings(f[0], f[1], f[2], s[0], s[1], s[2]);
  endtask

  initial begin
    int unsigned used;
    sb = new();
    voxel_ch.valid = 1'b0;
    voxel_ch.voxel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    dest_ch.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    used = 0;
    write_reg(REG_SPARE_LO, {CFG_DATA_BITS{1'b1}});
    write_reg(REG_SPARE_HI, '0);
    cfg_ch.valid <= 1'b0;
    apply_settings(4'd2, 4'd2, 4'd2, 13'd2, 13'd2, 13'd2);
    stream_volume(FILL_FULL, 1'b0, used);
    stream_volume(FILL_ZERO, 1'b1, used);
    apply_settings(4'd0, 4'd1, 4'd1, 13'd0, 13'd2, 13'd1);
    stream_volume(FILL_RANDOM, 1'b0, used);
    apply_settings(4'd15, 4'd1, 4'd1, 13'd3, 13'd1, 13'd1);
    stream_volume(FILL_RANDOM, 1'b0, used);

    used = 0;
    while (used < RANDOM_ITEMS) begin
      if (used >= 2 * RANDOM_ITEMS / 3) set_idle(0, 0);
      else if (used >= RANDOM_ITEMS / 3) set_idle(48, 15);
      else set_idle(15, 48);
      random_settings();
      repeat ($urandom_range(1, 2)) stream_volume(FILL_RANDOM, $urandom_range(0, 3) == 0, used);
    end

    set_idle(0, 0);
    apply_settings(4'd0, 4'd2, 4'd1, 13'd8191, 13'd2, 13'd1);
    stream_volume(FILL_RANDOM, 1'b0, used);
    apply_settings(4'd1, 4'd9, 4'd1, 13'd1, 13'd4096, 13'd1);
    stream_volume(FILL_RANDOM, 1'b0, used);
    apply_settings(4'd1, 4'd1, 4'd8, 13'd1, 13'd1, 13'd4097);
    stream_volume(FILL_RANDOM, 1'b0, used);

    hold_until_drained(SETTLE);
    if (sb.block_means.size() != 0) sb.report("items still outstanding at the end");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
